// File: sv/prime_snapped_delay_calculator_top_assert.svh
// assertion macros for the prime-snapped delay calculator
// expects clk and rst in the scope of the module that uses them
`ifndef PRIME_SNAPPED_DELAY_CALCULATOR_TOP_ASSERT_SVH
`define PRIME_SNAPPED_DELAY_CALCULATOR_TOP_ASSERT_SVH

// same-cycle implication
`define PSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/psd_pkg.sv
// shared widths, register indexes and remainder unit request/response types
// no dependencies
`default_nettype none

package psd_pkg;

  localparam int VW        = 12;              // delay value width
  localparam int IW        = 32;              // iteration width
  localparam int CW        = VW + 1;          // candidate width, candidate + 1 may reach 2^VW
  localparam int PW        = IW + VW;         // exact product width
  localparam int MOD_CNT_W = $clog2(PW + 1);

  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_MIN_DELAY = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_DELAY = 2'd1;

  typedef struct packed {
    logic                 start;
    logic [PW-1:0]        dividend;  // left aligned, msb first
    logic [MOD_CNT_W-1:0] nbits;
    logic [CW-1:0]        divisor;
  } mod_req_t;

  typedef struct packed {
    logic          done;
    logic [CW-1:0] rem;
  } mod_rsp_t;

endpackage

`default_nettype wire

// File: sv/psd_mod_unit.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on psd_pkg
`default_nettype none

module psd_mod_unit import psd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mod_req_t req,
  output mod_rsp_t      rsp
);

  logic                 busy;
  logic                 done;
  logic [MOD_CNT_W-1:0] cnt;
  logic [PW-1:0]        sh;
  logic [CW-1:0]        rem;
  logic [CW-1:0]        div;
  logic [CW:0]          trial;
  logic [CW:0]          diff;
  logic [CW-1:0]        rem_next;

  always_comb begin
    trial    = {rem, sh[PW-1]};
    diff     = trial - {1'b0, div};
    rem_next = (trial >= {1'b0, div}) ? diff[CW-1:0] : trial[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        sh   <= req.dividend;
        cnt  <= req.nbits;
        rem  <= '0;
        div  <= req.divisor;
        busy <= 1'b1;
      end else if (busy) begin
        sh  <= sh << 1;
        rem <= rem_next;
        cnt <= cnt - 1'b1;
        if (cnt == MOD_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

// File: sv/prime_snapped_delay_calculator_top.sv
// flow: when min_delay >= max_delay the item takes min_delay as its delay; otherwise the
//   remainder of iteration * min_delay by the span is added to min_delay, and candidates are
//   tested: even ones above 3 are rejected at once, odd ones by trial division by 3, then by
//   6k-1/6k+1 pairs (5, 7, 11, 13, ...) until a divisor hits or its square passes the candidate
// throughput: one item at a time, set by the single serial remainder unit
// reset: control cleared, min_delay = 3, max_delay = 11, no item pending
`default_nettype none

module prime_snapped_delay_calculator_top import psd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_index,
  input  wire logic [VW-1:0]    wr_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [IW-1:0]    iteration,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [VW-1:0]         delay
);

  `include "prime_snapped_delay_calculator_top_assert.svh"

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_OFS      = 4'd1;
  localparam logic [3:0] S_OFS_WAIT = 4'd2;
  localparam logic [3:0] S_T_START  = 4'd3;
  localparam logic [3:0] S_T_W3     = 4'd4;
  localparam logic [3:0] S_T_LOOP   = 4'd5;
  localparam logic [3:0] S_T_WA     = 4'd6;
  localparam logic [3:0] S_T_WB     = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  localparam logic [1:0] M_BASE  = 2'd0;
  localparam logic [1:0] M_ABOVE = 2'd1;
  localparam logic [1:0] M_BELOW = 2'd2;

  logic [3:0]      state;
  logic [1:0]      mode;
  logic [VW-1:0]   min_delay;
  logic [VW-1:0]   max_delay;
  logic [PW-1:0]   product;
  logic [VW-1:0]   span;
  logic [CW-1:0]   cand;
  logic [CW-1:0]   dv;
  logic [VW-1:0]   result;
  logic [2*CW-1:0] dv_sq;
  logic [CW-1:0]   cand_inc;
  logic [CW-1:0]   hi_ext;
  logic [PW-1:0]   cand_div;
  logic            verdict;
  logic            cand_prime;
  mod_req_t        mreq;
  mod_rsp_t        mrsp;

  psd_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign in_stall = (state != S_IDLE);
  assign dv_sq    = (2*CW)'(dv) * (2*CW)'(dv);
  assign cand_inc = cand + 1'b1;
  assign hi_ext   = CW'(max_delay);
  assign cand_div = {cand, {(PW-CW){1'b0}}};

  // trial division verdict and remainder requests
  always_comb begin
    verdict       = 1'b0;
    cand_prime    = 1'b0;
    mreq.start    = 1'b0;
    mreq.dividend = cand_div;
    mreq.nbits    = MOD_CNT_W'(CW);
    mreq.divisor  = dv;
    case (state)
      S_OFS: begin
        mreq.start    = 1'b1;
        mreq.dividend = product;
        mreq.nbits    = MOD_CNT_W'(PW);
        mreq.divisor  = CW'(span);
      end
      S_T_START: begin
        if (cand <= CW'(1)) begin
          verdict = 1'b1;
        end else if (cand <= CW'(3)) begin
          verdict    = 1'b1;
          cand_prime = 1'b1;
        end else if (!cand[0]) begin
          verdict = 1'b1;
        end else begin
          mreq.start   = 1'b1;
          mreq.divisor = CW'(3);
        end
      end
      S_T_W3: verdict = mrsp.done && (mrsp.rem == '0);
      S_T_LOOP: begin
        if (dv_sq > (2*CW)'(cand)) begin
          verdict    = 1'b1;
          cand_prime = 1'b1;
        end else begin
          mreq.start = 1'b1;
        end
      end
      S_T_WA: begin
        verdict      = mrsp.done && (mrsp.rem == '0);
        mreq.start   = mrsp.done && (mrsp.rem != '0);
        mreq.divisor = dv + CW'(2);
      end
      S_T_WB: verdict = mrsp.done && (mrsp.rem == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= M_BASE;
      min_delay <= VW'(3);
      max_delay <= VW'(11);
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        if (wr_index == REG_MIN_DELAY) begin
          min_delay <= wr_data;
        end else if (wr_index == REG_MAX_DELAY) begin
          max_delay <= wr_data;
        end
      end
      // a finishing item reloads the output itself
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      if (verdict) begin
        if (cand_prime) begin
          result <= cand[VW-1:0];
          state  <= S_FINISH;
        end else if (mode == M_BELOW) begin
          cand  <= cand - 1'b1;
          state <= S_T_START;
        end else if (cand_inc > hi_ext) begin
          // next candidate would pass the maximum, search downward instead
          mode <= M_BELOW;
          if (max_delay <= VW'(2)) begin
            result <= VW'(2);
            state  <= S_FINISH;
          end else begin
            cand  <= hi_ext - 1'b1;
            state <= S_T_START;
          end
        end else begin
          cand  <= cand_inc;
          mode  <= M_ABOVE;
          state <= S_T_START;
        end
      end else begin
        case (state)
          S_IDLE: begin
            if (in_valid) begin
              if (min_delay >= max_delay) begin
                result <= min_delay;
                state  <= S_FINISH;
              end else begin
                product <= PW'(iteration) * PW'(min_delay);
                span    <= max_delay - min_delay;
                state   <= S_OFS;
              end
            end
          end
          S_OFS: state <= S_OFS_WAIT;
          S_OFS_WAIT: begin
            if (mrsp.done) begin
              cand  <= CW'(min_delay) + mrsp.rem;
              mode  <= M_BASE;
              state <= S_T_START;
            end
          end
          S_T_START: state <= S_T_W3;
          S_T_W3: begin
            if (mrsp.done) begin
              dv    <= CW'(5);
              state <= S_T_LOOP;
            end
          end
          S_T_LOOP: state <= S_T_WA;
          S_T_WA: begin
            if (mrsp.done) begin
              state <= S_T_WB;
            end
          end
          S_T_WB: begin
            if (mrsp.done) begin
              dv    <= dv + CW'(6);
              state <= S_T_LOOP;
            end
          end
          S_FINISH: begin
            if (!out_valid || !out_stall) begin
              out_valid <= 1'b1;
              delay     <= result;
              state     <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  `PSD_ASSERT_NEXT(a_finish_loads, (state == S_FINISH) && (!out_valid || !out_stall),
    out_valid && (state == S_IDLE), "finished item not moved to output")
  `PSD_ASSERT_NOW(a_delay_bound, out_valid && (min_delay < max_delay),
    (delay <= max_delay) || (delay == VW'(2)), "delay above maximum")
  `PSD_ASSERT_NOW(a_done_expected, mrsp.done,
    (state == S_OFS_WAIT) || (state == S_T_W3) || (state == S_T_WA) || (state == S_T_WB),
    "remainder returned with no request pending")
  `PSD_ASSERT_NOW(a_below_floor, (mode == M_BELOW) && (state == S_T_START), cand >= CW'(2),
    "downward search passed below two")

endmodule

`default_nettype wire
